// ===== design/tfcw_pkg.sv =====
package tfcw_pkg;

  // Command codes of the request channel.
  localparam logic [2:0] CMD_PRINT     = 3'd0;
  localparam logic [2:0] CMD_SET       = 3'd1;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd2;
  localparam logic [2:0] CMD_CLEAR_ROW = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;

  // Printable character range.
  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h7f;

  // Internal cursor widths: the column field holds up to 255, the bank at most 7.
  localparam int CW = 8;
  localparam int BW = 3;

  // Glyph packing: five columns of eight bits, leftmost column in the top byte.
  localparam int GLYPH_BITS = 40;
  localparam int GLYPH_COLS = 5;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_PRINT = 6'b000100,
    ST_READ  = 6'b001000,
    ST_RDATA = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  // 5x7 font, one row per printable code starting at the space character.
  function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [6:0] idx);
    logic [GLYPH_BITS-1:0] g;
    case (idx)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00005f0000;
      7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147f147f14;
      7'd4:  g = 40'h242a7f2a12;
      7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250;
      7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001c224100;
      7'd9:  g = 40'h0041221c00;
      7'd10: g = 40'h14083e0814;
      7'd11: g = 40'h08083e0808;
      7'd12: g = 40'h0050300000;
      7'd13: g = 40'h0808080808;
      7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3e5149453e;
      7'd17: g = 40'h00427f4000;
      7'd18: g = 40'h4261514946;
      7'd19: g = 40'h2141454b31;
      7'd20: g = 40'h1814127f10;
      7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3c4a494930;
      7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h064949291e;
      7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0814224100;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0041221408;
      7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324979413e;
      7'd33: g = 40'h7e1111117e;
      7'd34: g = 40'h7f49494936;
      7'd35: g = 40'h3e41414122;
      7'd36: g = 40'h7f4141221c;
      7'd37: g = 40'h7f49494941;
      7'd38: g = 40'h7f09090901;
      7'd39: g = 40'h3e4149497a;
      7'd40: g = 40'h7f0808087f;
      7'd41: g = 40'h00417f4100;
      7'd42: g = 40'h2040413f01;
      7'd43: g = 40'h7f08142241;
      7'd44: g = 40'h7f40404040;
      7'd45: g = 40'h7f020c027f;
      7'd46: g = 40'h7f0408107f;
      7'd47: g = 40'h3e4141413e;
      7'd48: g = 40'h7f09090906;
      7'd49: g = 40'h3e4151215e;
      7'd50: g = 40'h7f09192946;
      7'd51: g = 40'h4649494931;
      7'd52: g = 40'h01017f0101;
      7'd53: g = 40'h3f4040403f;
      7'd54: g = 40'h1f2040201f;
      7'd55: g = 40'h3f4038403f;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807;
      7'd58: g = 40'h6151494543;
      7'd59: g = 40'h007f414100;
      7'd60: g = 40'h0204081020;
      7'd61: g = 40'h0041417f00;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;
      7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7f48444438;
      7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487f;
      7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087e090102;
      7'd71: g = 40'h0c5252523e;
      7'd72: g = 40'h7f08040478;
      7'd73: g = 40'h00447d4000;
      7'd74: g = 40'h2040443d00;
      7'd75: g = 40'h7f10284400;
      7'd76: g = 40'h00417f4000;
      7'd77: g = 40'h7c04180478;
      7'd78: g = 40'h7c08040478;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7c14141408;
      7'd81: g = 40'h081414187c;
      7'd82: g = 40'h7c08040408;
      7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043f444020;
      7'd85: g = 40'h3c4040207c;
      7'd86: g = 40'h1c2040201c;
      7'd87: g = 40'h3c4030403c;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h0c5050503c;
      7'd90: g = 40'h4464544c44;
      7'd91: g = 40'h0008364100;
      7'd92: g = 40'h00007f0000;
      7'd93: g = 40'h0041360800;
      7'd94: g = 40'h1008081008;
      7'd95: g = 40'h7846414678;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== design/tfcw_cmd_if.sv =====
// Request channel: one command with its operands.
interface tfcw_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] char_code;
  logic [7:0] col_in;
  logic [7:0] row_in;

  modport source (output valid, output cmd, output char_code, output col_in,
                  output row_in, input ready);
  modport sink   (input valid, input cmd, input char_code, input col_in,
                  input row_in, output ready);
endinterface

// ===== design/tfcw_res_if.sv =====
// Result channel: one answer per request.
interface tfcw_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       accepted;
  logic [6:0] cursor_col;
  logic [2:0] cursor_row;

  modport source (output valid, output read_data, output accepted,
                  output cursor_col, output cursor_row, input ready);
  modport sink   (input valid, input read_data, input accepted,
                  input cursor_col, input cursor_row, output ready);
endinterface

// ===== design/tfcw_ram.sv =====
// Single-port RAM with a registered read.
module tfcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/text_framebuffer_char_writer_core.sv =====
// Text-mode character writer over a byte framebuffer of COLUMNS x BANKS bytes.
// The request channel carries a command (print a character, place the cursor,
// clear everything, clear one bank, read one byte); the result channel returns
// exactly one answer per request with the read byte, an accepted flag and the
// cursor after the request. Both channels move a request on valid and ready.
// All framebuffer traffic goes through one RAM port, one byte per cycle. The
// work from acceptance to the result being offered is:
//   print_char        six byte writes: five glyph columns and a spacer,
//   read              an address state, then the registered RAM read,
//   clear_row         COLUMNS byte writes,  clear_all  COLUMNS*BANKS writes,
//   everything else   nothing beyond loading the result.
// Ready returns as the result is loaded into the output register, so the
// next request can follow only once the previous result is loaded.
// Only one request is in work; a finished result sits in an output register,
// so the next request may be taken while the receiver stalls. A further
// result waits in the sequencer, with ready low, until that register is free.
// After reset the cursor is at column 0 of bank 0 and all COLUMNS*BANKS
// bytes of the framebuffer (504 for the default size) are swept to zero, one
// byte per cycle, before the first request is taken.
module text_framebuffer_char_writer_core #(
  parameter int COLUMNS = 84,
  parameter int BANKS   = 6
) (
  input  logic       clk,
  input  logic       rst,
  tfcw_cmd_if.sink   request,
  tfcw_res_if.source result
);

  localparam int DEPTH = COLUMNS * BANKS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = tfcw_pkg::CW;
  localparam int BW    = tfcw_pkg::BW;
  localparam int GB    = tfcw_pkg::GLYPH_BITS;

  tfcw_pkg::state_t state;

  logic [CW-1:0] col;
  logic [BW-1:0] bank;
  logic [GB-1:0] glyph;
  logic [2:0]    cnt;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] clr_last;
  logic [AW-1:0] rd_addr;
  logic          pending;
  logic [7:0]    res_data;
  logic          res_ok;

  logic          out_valid;
  logic [7:0]    out_data;
  logic          out_ok;
  logic [6:0]    out_col;
  logic [2:0]    out_row;

  // Cursor wrap before each printed byte.
  logic          wrap;
  logic [CW-1:0] wcol;
  logic [BW-1:0] wbank;
  logic [AW-1:0] pr_addr;

  // Operand decode at acceptance.
  logic [CW-1:0] col_c;
  logic [BW-1:0] bank_c;
  logic          printable;
  logic          row_ok;
  logic [AW-1:0] row_base;

  // RAM port.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  always_comb begin
    wrap  = col > CW'(COLUMNS - 1);
    wcol  = wrap ? '0 : col;
    wbank = bank;
    if (wrap) begin
      wbank = (bank == BW'(BANKS - 1)) ? '0 : bank + 1'b1;
    end
    pr_addr = AW'(wbank) * AW'(COLUMNS) + AW'(wcol);
  end

  always_comb begin
    col_c     = (request.col_in > 8'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : request.col_in;
    bank_c    = (request.row_in > 8'(BANKS - 1)) ? BW'(BANKS - 1) : request.row_in[BW-1:0];
    printable = (request.char_code >= tfcw_pkg::FIRST_CODE) &&
                (request.char_code <= tfcw_pkg::LAST_CODE);
    row_ok    = request.row_in <= 8'(BANKS - 1);
    row_base  = AW'(request.row_in[BW-1:0]) * AW'(COLUMNS);
  end

  // The single address path into the framebuffer.
  always_comb begin
    ram_we    = (state == tfcw_pkg::ST_CLEAR) || (state == tfcw_pkg::ST_PRINT);
    ram_wdata = (state == tfcw_pkg::ST_PRINT) ? glyph[GB-1 -: 8] : 8'h00;
    case (state)
      tfcw_pkg::ST_CLEAR: ram_addr = clr_addr;
      tfcw_pkg::ST_PRINT: ram_addr = pr_addr;
      default:            ram_addr = rd_addr;
    endcase
  end

  tfcw_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tfcw_pkg::ST_CLEAR;
      clr_addr  <= '0;
      clr_last  <= AW'(DEPTH - 1);
      pending   <= 1'b0;
      col       <= '0;
      bank      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        tfcw_pkg::ST_IDLE: begin
          if (request.valid) begin
            res_data <= 8'h00;
            res_ok   <= 1'b1;
            state    <= tfcw_pkg::ST_DONE;
            case (request.cmd)
              tfcw_pkg::CMD_PRINT: begin
                if (printable) begin
                  glyph <= tfcw_pkg::font_glyph(request.char_code[6:0] -
                                                tfcw_pkg::FIRST_CODE[6:0]);
                  cnt   <= '0;
                  state <= tfcw_pkg::ST_PRINT;
                end else begin
                  res_ok <= 1'b0;
                end
              end
              tfcw_pkg::CMD_SET: begin
                col  <= col_c;
                bank <= bank_c;
              end
              tfcw_pkg::CMD_CLEAR_ALL: begin
                clr_addr <= '0;
                clr_last <= AW'(DEPTH - 1);
                pending  <= 1'b1;
                state    <= tfcw_pkg::ST_CLEAR;
              end
              tfcw_pkg::CMD_CLEAR_ROW: begin
                if (row_ok) begin
                  clr_addr <= row_base;
                  clr_last <= row_base + AW'(COLUMNS - 1);
                  pending  <= 1'b1;
                  state    <= tfcw_pkg::ST_CLEAR;
                end else begin
                  res_ok <= 1'b0;
                end
              end
              tfcw_pkg::CMD_READ: begin
                rd_addr <= AW'(bank_c) * AW'(COLUMNS) + AW'(col_c);
                state   <= tfcw_pkg::ST_READ;
              end
              default: begin
                res_ok <= 1'b0;
              end
            endcase
          end
        end
        tfcw_pkg::ST_CLEAR: begin
          if (clr_addr == clr_last) begin
            state <= pending ? tfcw_pkg::ST_DONE : tfcw_pkg::ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        tfcw_pkg::ST_PRINT: begin
          // Five glyph columns shift out, then zeros give the spacer.
          col   <= wcol + 1'b1;
          bank  <= wbank;
          glyph <= glyph << 8;
          cnt   <= cnt + 1'b1;
          if (cnt == 3'(tfcw_pkg::GLYPH_COLS)) begin
            state <= tfcw_pkg::ST_DONE;
          end
        end
        tfcw_pkg::ST_READ: begin
          state <= tfcw_pkg::ST_RDATA;
        end
        tfcw_pkg::ST_RDATA: begin
          res_data <= ram_rdata;
          state    <= tfcw_pkg::ST_DONE;
        end
        tfcw_pkg::ST_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_data  <= res_data;
            out_ok    <= res_ok;
            out_col   <= col[6:0];
            out_row   <= bank;
            pending   <= 1'b0;
            state     <= tfcw_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= tfcw_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign request.ready     = (state == tfcw_pkg::ST_IDLE);
  assign result.valid      = out_valid;
  assign result.read_data  = out_data;
  assign result.accepted   = out_ok;
  assign result.cursor_col = out_col;
  assign result.cursor_row = out_row;

  // The cursor bank never leaves the framebuffer.
  a_bank_range: assert property (@(posedge clk) disable iff (rst)
    bank <= BW'(BANKS - 1))
    else $error("cursor bank out of range");

  // The cursor column stops at most one past the last column.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= CW'(COLUMNS))
    else $error("cursor column out of range");

  // A new result is only loaded from the completion state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == tfcw_pkg::ST_DONE)
    else $error("result raised outside completion");

  // A print always ends after exactly six byte writes.
  a_print_len: assert property (@(posedge clk) disable iff (rst)
    (state == tfcw_pkg::ST_PRINT && cnt == 3'(tfcw_pkg::GLYPH_COLS))
      |=> state == tfcw_pkg::ST_DONE)
    else $error("print did not finish after six bytes");

  // A clear sweep stays within its own range.
  a_clear_bound: assert property (@(posedge clk) disable iff (rst)
    state == tfcw_pkg::ST_CLEAR |-> clr_addr <= clr_last)
    else $error("clear sweep overran its range");

endmodule
